// ----- rtl/core/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg
// shared types and constants of the 7x7 rgb box mean filter
// ----------------------------------------------------------------------------
package bmf_pkg;

    // geometry
    localparam int MAX_WIDTH   = 2048;
    localparam int WIN         = 7;
    localparam int HALF        = WIN / 2;
    localparam int LINES       = WIN - 1;
    localparam int FIRST_CTR   = WIN - 2;
    localparam int EMIT_START  = FIRST_CTR + HALF;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);

    // field widths
    localparam int CHAN_W      = 8;
    localparam int CHANNELS    = 3;
    localparam int PIX_W       = CHAN_W * CHANNELS;
    localparam int POS_W       = 11;
    localparam int SIZE_W      = 12;
    localparam int CFG_INDEX_W = 4;

    // sums: one column of WIN pixels, and the whole window
    localparam int COL_SUM_W   = $clog2(WIN * 255 + 1);
    localparam int WIN_SUM_W   = $clog2(WIN * WIN * 255 + 1);

    // floor(v / 49) as (v * RECIP) >> RECIP_SHIFT, exact for v below WIN*WIN*256
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + WIN * WIN - 1) / (WIN * WIN);
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = WIN_SUM_W + RECIP_W;

    // result queue
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 12'd480;

    typedef logic [CHAN_W-1:0]          chan_t;
    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [SIZE_W-1:0]          size_t;
    typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [PIX_W-1:0]           pixel_t;
    typedef logic [LINES*PIX_W-1:0]     line_word_t;
    typedef logic [COL_SUM_W-1:0]       col_sum_t;
    typedef logic [WIN_SUM_W-1:0]       win_sum_t;

    // bookkeeping that travels with a pixel down the pipe
    typedef struct packed {
        logic  emit;
        logic  done;
        pos_t  row;
        pos_t  col;
    } meta_t;

    // one result request
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
        pos_t  row;
        pos_t  col;
        logic  done;
    } result_t;

endpackage

// ----- rtl/core/bmf_result_fifo.sv -----
// ----------------------------------------------------------------------------
// bmf_result_fifo
// small result queue between the filter pipe and the output channel
// ----------------------------------------------------------------------------
module bmf_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bmf_pkg::result_t  push_data,
    input  logic              pop,
    output logic              out_valid,
    output bmf_pkg::result_t  out_data
);
    import bmf_pkg::*;

    result_t                 store [FIFO_DEPTH];
    logic [FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;

    // space is guaranteed by the upstream credit count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + FIFO_AW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + FIFO_AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = store[rd_ptr_reg];

endmodule

// ----- rtl/core/box_mean_filter_7x7_rgb_unit.sv -----
// ----------------------------------------------------------------------------
// box_mean_filter_7x7_rgb_unit
// 7x7 box mean over a raster stream of rgb pixels
// ----------------------------------------------------------------------------
// Takes one pixel per clock while s_ready is high, in raster order, and for
// each center pixel whose row and column lie in 5 .. size-6, returns
// floor(sum of the 7x7 window / 49) per channel with the center coordinates;
// frame_done marks the last center of a frame. The result belongs to the
// pixel three rows and three columns past the center. The six previous rows
// live in one 2048 x 144 bit line memory (one read and one write per cycle,
// a whole column of six pixels per entry), so the sustained rate is one
// pixel per clock while s_ready is high, set by that single read-modify-write
// per column. The line memory needs no clearing pass after reset. An 8-deep
// result queue sits before the output, and s_ready stays high as long as
// fewer than 8 results are owed downstream. The user must write frame_width
// and frame_height through the cfg port while the block is idle; the block
// itself does not enforce it. 0 acts as 1 and values above 2048 act as 2048.
// ----------------------------------------------------------------------------
module box_mean_filter_7x7_rgb_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    // pixel requests
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bmf_pkg::chan_t       s_blue_in,
    input  bmf_pkg::chan_t       s_green_in,
    input  bmf_pkg::chan_t       s_red_in,
    input  logic                 s_frame_start,
    // result requests
    output logic                 m_valid,
    input  logic                 m_ready,
    output bmf_pkg::chan_t       m_blue_mean,
    output bmf_pkg::chan_t       m_green_mean,
    output bmf_pkg::chan_t       m_red_mean,
    output bmf_pkg::pos_t        m_center_row,
    output bmf_pkg::pos_t        m_center_col,
    output logic                 m_frame_done,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  bmf_pkg::cfg_index_t  cfg_index,
    input  bmf_pkg::size_t       cfg_data
);
    import bmf_pkg::*;

    // ---------------- configuration ----------------
    size_t width_reg, height_reg;
    size_t w_eff, h_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                width_reg <= cfg_data;
            end
            if (cfg_index == REG_FRAME_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    // zero acts as one, oversize saturates
    always_comb begin
        if (width_reg == '0) begin
            w_eff = SIZE_W'(1);
        end else if (width_reg > SIZE_W'(MAX_WIDTH)) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = SIZE_W'(1);
        end else if (height_reg > SIZE_W'(MAX_WIDTH)) begin
            h_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            h_eff = height_reg;
        end
    end

    // ---------------- intake and raster position ----------------
    logic  accept;
    pos_t  row_reg, row_next, col_reg, col_next;
    pos_t  row_cur, col_cur;
    size_t row_inc, col_inc;
    meta_t meta_cur;
    logic [FIFO_CNT_W-1:0] pending_reg, pending_next;

    // credit: every accepted pixel that owes a result holds one queue slot
    assign s_ready = (pending_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept  = s_valid && s_ready;

    always_comb begin
        row_cur = s_frame_start ? '0 : row_reg;
        col_cur = s_frame_start ? '0 : col_reg;
        row_inc = {1'b0, row_cur} + SIZE_W'(1);
        col_inc = {1'b0, col_cur} + SIZE_W'(1);

        // wrap at the end of a row, and at the end of the frame
        row_next = row_cur;
        col_next = col_inc[POS_W-1:0];
        if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
        end

        // center sits HALF rows and columns behind the incoming pixel
        meta_cur.emit = (row_cur >= POS_W'(EMIT_START))
                     && (col_cur >= POS_W'(EMIT_START))
                     && (({1'b0, row_cur} + SIZE_W'(WIN - HALF)) < (h_eff + SIZE_W'(2)))
                     && (({1'b0, col_cur} + SIZE_W'(WIN - HALF)) < (w_eff + SIZE_W'(2)));
        meta_cur.done = (({1'b0, row_cur} + SIZE_W'(WIN - HALF)) == (h_eff + SIZE_W'(1)))
                     && (({1'b0, col_cur} + SIZE_W'(WIN - HALF)) == (w_eff + SIZE_W'(1)));
        meta_cur.row  = row_cur - POS_W'(HALF);
        meta_cur.col  = col_cur - POS_W'(HALF);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---------------- line memory, stage 1 ----------------
    // one entry per column: six stacked pixels, oldest row in the low bits
    line_word_t line_mem [MAX_WIDTH];
    line_word_t rd_word_reg, fwd_word_reg, old_word, wr_word;
    addr_t      s1_addr_reg, addr_cur;
    pixel_t     s1_pix_reg;
    logic       s1_valid_reg, s1_fwd_reg;
    meta_t      s1_meta_reg;
    col_sum_t   col_sum [CHANNELS];

    assign addr_cur = addr_t'(col_cur);

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_word_reg <= line_mem[addr_cur];
        end
        if (s1_valid_reg) begin
            line_mem[s1_addr_reg] <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= {s_red_in, s_green_in, s_blue_in};
            s1_addr_reg <= addr_cur;
            s1_meta_reg <= meta_cur;
            // same column written at this edge: memory read returns stale data
            s1_fwd_reg  <= s1_valid_reg && (s1_addr_reg == addr_cur);
        end
        if (s1_valid_reg) begin
            fwd_word_reg <= wr_word;
        end
    end

    always_comb begin
        old_word = s1_fwd_reg ? fwd_word_reg : rd_word_reg;
        // shift the column up one row, new pixel at the bottom
        wr_word  = {s1_pix_reg, old_word[LINES*PIX_W-1:PIX_W]};
        for (int ch = 0; ch < CHANNELS; ch++) begin
            col_sum[ch] = COL_SUM_W'(s1_pix_reg[ch*CHAN_W +: CHAN_W]);
            for (int r = 0; r < LINES; r++) begin
                col_sum[ch] = col_sum[ch]
                            + COL_SUM_W'(old_word[r*PIX_W + ch*CHAN_W +: CHAN_W]);
            end
        end
    end

    // ---------------- stage 2: column sums ----------------
    logic     s2_valid_reg;
    meta_t    s2_meta_reg;
    col_sum_t s2_sum_reg [CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_meta_reg <= s1_meta_reg;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                s2_sum_reg[ch] <= col_sum[ch];
            end
        end
    end

    // ---------------- stage 3: window sum ----------------
    // the window slides by one column on every pixel, row ends included;
    // the sum is rebuilt from the last seven column sums each time
    col_sum_t hist_reg  [WIN][CHANNELS];
    win_sum_t total_reg [CHANNELS];
    win_sum_t win_sum   [CHANNELS];
    logic     s3_valid_reg;
    meta_t    s3_meta_reg;

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            win_sum[ch] = WIN_SUM_W'(s2_sum_reg[ch]);
            for (int c = 1; c < WIN; c++) begin
                win_sum[ch] = win_sum[ch] + WIN_SUM_W'(hist_reg[c][ch]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < WIN; c++) begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    hist_reg[c][ch] <= '0;
                end
            end
            for (int ch = 0; ch < CHANNELS; ch++) begin
                total_reg[ch] <= '0;
            end
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg && s2_meta_reg.emit;
            if (s2_valid_reg) begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    for (int c = 0; c < WIN - 1; c++) begin
                        hist_reg[c][ch] <= hist_reg[c+1][ch];
                    end
                    hist_reg[WIN-1][ch] <= s2_sum_reg[ch];
                    total_reg[ch] <= win_sum[ch];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            s3_meta_reg <= s2_meta_reg;
        end
    end

    // ---------------- divide by 49, into the result queue ----------------
    logic [PROD_W-1:0] prod [CHANNELS];
    result_t           push_data, out_data;
    logic              pop;

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            prod[ch] = PROD_W'(total_reg[ch]) * PROD_W'(RECIP);
        end
        push_data.blue  = prod[0][RECIP_SHIFT +: CHAN_W];
        push_data.green = prod[1][RECIP_SHIFT +: CHAN_W];
        push_data.red   = prod[2][RECIP_SHIFT +: CHAN_W];
        push_data.row   = s3_meta_reg.row;
        push_data.col   = s3_meta_reg.col;
        push_data.done  = s3_meta_reg.done;
    end

    assign pop = m_valid && m_ready;

    bmf_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s3_valid_reg),
        .push_data (push_data),
        .pop       (pop),
        .out_valid (m_valid),
        .out_data  (out_data)
    );

    // results owed: counted at intake, released at delivery
    always_comb begin
        pending_next = pending_reg;
        if ((accept && meta_cur.emit) && !pop) begin
            pending_next = pending_reg + FIFO_CNT_W'(1);
        end else if (!(accept && meta_cur.emit) && pop) begin
            pending_next = pending_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    assign m_blue_mean  = out_data.blue;
    assign m_green_mean = out_data.green;
    assign m_red_mean   = out_data.red;
    assign m_center_row = out_data.row;
    assign m_center_col = out_data.col;
    assign m_frame_done = out_data.done;

endmodule

// ----- rtl/core/bmf_checker.sv -----
// ----------------------------------------------------------------------------
// bmf_checker
// port-level checks of the box mean filter, bound to the top level
// ----------------------------------------------------------------------------
module bmf_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  bmf_pkg::chan_t       m_blue_mean,
    input  bmf_pkg::chan_t       m_green_mean,
    input  bmf_pkg::chan_t       m_red_mean,
    input  bmf_pkg::pos_t        m_center_row,
    input  bmf_pkg::pos_t        m_center_col,
    input  logic                 m_frame_done
);
    import bmf_pkg::*;

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_blue_mean) && $stable(m_green_mean)
            && $stable(m_red_mean) && $stable(m_center_row) && $stable(m_center_col)
            && $stable(m_frame_done))
        else $error("result changed while stalled");

    // centers never lie in the border band
    a_center_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_center_row >= POS_W'(FIRST_CTR)) && (m_center_col >= POS_W'(FIRST_CTR)))
        else $error("result for a border center");

    // nothing is owed right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result presented after reset");

    // intake only closes when a pixel was just taken
    a_ready_falls_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_ready))
        else $error("s_ready fell without an accepted pixel");

endmodule

bind box_mean_filter_7x7_rgb_unit bmf_checker u_bmf_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 7x7 rgb box mean filter
// ----------------------------------------------------------------------------
// Streams pixel requests into the block while a bit-accurate software copy of
// the filter (line rows, 7x7 window, raster position) works out each mean
// and its center coordinates. Results are matched in order, field by field.
// Directed frames cover the smallest result-bearing frame, all-zero and
// all-max content, zero and tiny sizes, saturated sizes, mid-frame size
// changes and restarts; random frames follow, with random gaps on both sides
// and one long receiver hold-off that backs up the block.
// ----------------------------------------------------------------------------
module tb_top;
    import bmf_pkg::*;

    localparam int          HALF_PERIOD   = 5;
    localparam longint      RUN_LIMIT_NS  = 60_000_000;
    localparam int unsigned RANDOM_ITEMS  = 100;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam int unsigned AREA          = WIN * WIN;
    // index that maps to no register, written once to show it is ignored
    localparam cfg_index_t  SPARE_REG     = 4'd14;

    typedef enum {FILL_RANDOM, FILL_EXTREME, FILL_ZERO, FILL_FULL} fill_e;

    // one pixel request as queued for the driver
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
        logic  start;
    } pixel_req_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // block inputs, all known from time zero
    logic       s_valid       = 1'b0;
    chan_t      s_blue_in     = '0;
    chan_t      s_green_in    = '0;
    chan_t      s_red_in      = '0;
    logic       s_frame_start = 1'b0;
    logic       m_ready       = 1'b0;
    logic       cfg_valid     = 1'b0;
    cfg_index_t cfg_index     = '0;
    size_t      cfg_data      = '0;

    // block outputs
    logic  s_ready;
    logic  m_valid;
    chan_t m_blue_mean;
    chan_t m_green_mean;
    chan_t m_red_mean;
    pos_t  m_center_row;
    pos_t  m_center_col;
    logic  m_frame_done;
    logic  cfg_ready;

    // pixel requests waiting to be driven, and means still owed by the block
    pixel_req_t pixel_backlog[$];
    result_t    owed_means[$];

    // software copy of the filter state
    bit [PIX_W-1:0] line_mem [LINES][MAX_WIDTH];
    bit [PIX_W-1:0] win_px [WIN][WIN];
    int unsigned    row_pos = 0;
    int unsigned    col_pos = 0;
    size_t          frame_width_q  = RESET_WIDTH;
    size_t          frame_height_q = RESET_HEIGHT;

    // gap control on both sides; calm means no idling at all
    int unsigned send_gap   = 0;
    int unsigned sink_gap   = 0;
    bit          sender_calm = 1'b0;
    bit          sink_calm   = 1'b0;
    bit          hold_arm    = 1'b0;
    logic        long_hold   = 1'b0;

    // run statistics
    int unsigned mismatches         = 0;
    int unsigned means_checked      = 0;
    int unsigned pixels_taken       = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned register_writes    = 0;

    box_mean_filter_7x7_rgb_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_blue_in     (s_blue_in),
        .s_green_in    (s_green_in),
        .s_red_in      (s_red_in),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_blue_mean   (m_blue_mean),
        .m_green_mean  (m_green_mean),
        .m_red_mean    (m_red_mean),
        .m_center_row  (m_center_row),
        .m_center_col  (m_center_col),
        .m_frame_done  (m_frame_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // zero acts as one, anything past 2048 saturates (same bound for rows)
    function automatic int unsigned effective_size(input size_t v);
        if (v == 0) return 1;
        if (v > MAX_WIDTH) return MAX_WIDTH;
        return v;
    endfunction

    function automatic chan_t make_chan(input fill_e fill);
        case (fill)
            FILL_ZERO:    return '0;
            FILL_FULL:    return '1;
            FILL_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
            default:      return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [11:0] got,
                                   input logic [11:0] want, input pos_t row,
                                   input pos_t col);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: got %0d expected %0d (center row %0d col %0d)",
                     what, got, want, row, col);
    endtask

    // one accepted pixel through the filter copy; may owe one mean
    task automatic filter_pixel(input pixel_req_t req);
        int unsigned    w, h, y, x, cy, cx;
        int unsigned    sum_b, sum_g, sum_r;
        bit [PIX_W-1:0] fresh;
        bit [PIX_W-1:0] column [WIN];
        result_t        mean;
        w = effective_size(frame_width_q);
        h = effective_size(frame_height_q);
        fresh = {req.red, req.green, req.blue};
        if (req.start) begin
            row_pos = 0;
            col_pos = 0;
        end
        y = row_pos;
        x = col_pos;
        // column of the window: six stored rows above, then the new pixel
        for (int r = 0; r < LINES; r++) column[r] = line_mem[r][x];
        column[LINES] = fresh;
        for (int r = 0; r < LINES - 1; r++) line_mem[r][x] = line_mem[r + 1][x];
        line_mem[LINES - 1][x] = fresh;
        for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN - 1; c++) win_px[r][c] = win_px[r][c + 1];
            win_px[r][WIN - 1] = column[r];
        end
        // center sits three rows and three columns behind the new pixel
        if (y >= EMIT_START && x >= EMIT_START) begin
            cy = y - HALF;
            cx = x - HALF;
            if (cy + WIN < h + 2 && cx + WIN < w + 2) begin
                sum_b = 0;
                sum_g = 0;
                sum_r = 0;
                for (int r = 0; r < WIN; r++) begin
                    for (int c = 0; c < WIN; c++) begin
                        sum_b += win_px[r][c][7:0];
                        sum_g += win_px[r][c][15:8];
                        sum_r += win_px[r][c][23:16];
                    end
                end
                mean.blue  = chan_t'(sum_b / AREA);
                mean.green = chan_t'(sum_g / AREA);
                mean.red   = chan_t'(sum_r / AREA);
                mean.row   = pos_t'(cy);
                mean.col   = pos_t'(cx);
                mean.done  = (cy + WIN == h + 1) && (cx + WIN == w + 1);
                owed_means.push_back(mean);
            end
        end
        // raster advance; a position past a shrunken size wraps here too
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
        end
    endtask

    task automatic check_mean();
        result_t want;
        means_checked++;
        if (owed_means.size() == 0) begin
            report_mismatch("result with none owed, row", 12'(m_center_row), '0,
                            m_center_row, m_center_col);
            return;
        end
        want = owed_means.pop_front();
        if (m_blue_mean !== want.blue)
            report_mismatch("blue_mean", 12'(m_blue_mean), 12'(want.blue),
                            want.row, want.col);
        if (m_green_mean !== want.green)
            report_mismatch("green_mean", 12'(m_green_mean), 12'(want.green),
                            want.row, want.col);
        if (m_red_mean !== want.red)
            report_mismatch("red_mean", 12'(m_red_mean), 12'(want.red),
                            want.row, want.col);
        if (m_center_row !== want.row)
            report_mismatch("center_row", 12'(m_center_row), 12'(want.row),
                            want.row, want.col);
        if (m_center_col !== want.col)
            report_mismatch("center_col", 12'(m_center_col), 12'(want.col),
                            want.row, want.col);
        if (m_frame_done !== want.done)
            report_mismatch("frame_done", 12'(m_frame_done), 12'(want.done),
                            want.row, want.col);
    endtask

    // queue a run of pixels; stray sprinkles frame_start through the run
    task automatic push_run(input int unsigned count, input bit first_start,
                            input fill_e fill, input bit stray);
        pixel_req_t req;
        for (int unsigned n = 0; n < count; n++) begin
            req.blue  = make_chan(fill);
            req.green = make_chan(fill);
            req.red   = make_chan(fill);
            req.start = (n == 0) ? first_start : (stray && $urandom_range(0, 19) == 0);
            pixel_backlog.push_back(req);
        end
    endtask

    // register write request, only issued while the block is idle
    task automatic write_register(input cfg_index_t idx, input size_t value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH) frame_width_q = value;
        else if (idx == REG_FRAME_HEIGHT) frame_height_q = value;
        register_writes++;
    endtask

    task automatic set_geometry(input size_t cols, input size_t rows);
        write_register(REG_FRAME_WIDTH, cols);
        write_register(REG_FRAME_HEIGHT, rows);
    endtask

    // sender pauses until every pixel is in and every mean is out,
    // then leaves time for the pipe to empty of resultless pixels
    task automatic settle();
        while (pixel_backlog.size() != 0 || s_valid || owed_means.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // pixel driver: one request at a time, random gaps between requests
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : pixel_driver
        pixel_req_t taken;
        pixel_req_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                taken = {s_blue_in, s_green_in, s_red_in, s_frame_start};
                filter_pixel(taken);
                pixels_taken++;
            end
            if (s_valid && !s_ready) input_stall_cycles++;
            // payload only moves once the current request is gone
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pixel_backlog.size() != 0) begin
                    nxt = pixel_backlog.pop_front();
                    s_valid       <= 1'b1;
                    s_blue_in     <= nxt.blue;
                    s_green_in    <= nxt.green;
                    s_red_in      <= nxt.red;
                    s_frame_start <= nxt.start;
                    send_gap      <= pick_gap(sender_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks every accepted mean, stalls at random
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : mean_monitor
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) check_mean();
            if (long_hold) begin
                m_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                m_ready  <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else begin
                m_ready  <= 1'b1;
                sink_gap <= pick_gap(sink_calm);
            end
        end
    end

    // long receiver hold-off so the result queue fills and s_ready drops
    initial begin : long_hold_off
        int unsigned held;
        wait (hold_arm);
        @(posedge aclk);
        long_hold <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
        long_hold <= 1'b0;
    end

    // run limit
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("timeout: run did not complete within %0d ns", RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        size_t       cols, rows;
        int unsigned area, count, frames, kind, waited, random_items;
        bit          need_start;
        fill_e       fill;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry, position starts at the origin without frame_start
        push_run(12, 1'b0, FILL_EXTREME, 1'b0);
        settle();

        // smallest frame that yields a mean: all max, then all zero with
        // the wrap at end of frame standing in for frame_start
        set_geometry(12'd11, 12'd11);
        push_run(121, 1'b1, FILL_FULL, 1'b0);
        push_run(121, 1'b0, FILL_ZERO, 1'b0);
        settle();

        // zero size acts as one, tiny and too-small frames give nothing
        set_geometry(12'd0, 12'd0);
        push_run(4, 1'b0, FILL_EXTREME, 1'b0);
        settle();
        set_geometry(12'd7, 12'd7);
        push_run(49, 1'b1, FILL_RANDOM, 1'b0);
        settle();
        set_geometry(12'd10, 12'd11);
        push_run(110, 1'b1, FILL_RANDOM, 1'b0);
        settle();

        // sizes shrink under a frame in flight: rows past the new height
        // and a column past the new width both wrap to the origin
        set_geometry(12'd20, 12'd16);
        push_run(200, 1'b1, FILL_RANDOM, 1'b0);
        settle();
        write_register(REG_FRAME_HEIGHT, 12'd9);
        push_run(17, 1'b0, FILL_RANDOM, 1'b0);
        settle();
        write_register(REG_FRAME_WIDTH, 12'd14);
        push_run(40, 1'b0, FILL_RANDOM, 1'b0);
        settle();

        // frame abandoned partway by a fresh frame_start
        set_geometry(12'd12, 12'd12);
        push_run(100, 1'b1, FILL_RANDOM, 1'b0);
        push_run(144, 1'b1, FILL_RANDOM, 1'b0);
        settle();

        // back pressure: receiver holds off while pixels keep coming
        set_geometry(12'd16, 12'd16);
        sender_calm = 1'b1;
        push_run(256, 1'b1, FILL_RANDOM, 1'b0);
        hold_arm = 1'b1;
        settle();
        sender_calm = 1'b0;

        // width saturates at 2048; a short run, no center qualifies yet
        write_register(SPARE_REG, size_t'($urandom_range(0, 4095)));
        set_geometry(12'd4095, 12'd11);
        sender_calm = 1'b1;
        sink_calm   = 1'b1;
        push_run(20, 1'b1, FILL_RANDOM, 1'b0);
        settle();
        sender_calm = 1'b0;
        sink_calm   = 1'b0;

        // height saturates; partial frame only
        set_geometry(12'd11, 12'd4095);
        push_run(11 * 10, 1'b1, FILL_RANDOM, 1'b0);
        settle();

        // random rounds: mostly whole frames with random content, some cut
        // short and some noise with stray frame_start requests
        need_start   = 1'b1;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 3) != 0) begin
                kind = $urandom_range(0, 9);
                cols = (kind < 7) ? size_t'($urandom_range(11, 22)) :
                       (kind < 9) ? size_t'($urandom_range(1, 10)) : size_t'(0);
                rows = ($urandom_range(0, 9) < 7) ? size_t'($urandom_range(11, 18)) :
                       size_t'($urandom_range(0, 10));
                set_geometry(cols, rows);
                // a new size always begins at the origin
                need_start = 1'b1;
            end
            sender_calm = ($urandom_range(0, 4) == 0);
            sink_calm   = ($urandom_range(0, 4) == 0);
            area   = effective_size(frame_width_q) * effective_size(frame_height_q);
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames && random_items < RANDOM_ITEMS; f++) begin
                fill = ($urandom_range(0, 5) == 0) ? FILL_EXTREME : FILL_RANDOM;
                kind = $urandom_range(0, 9);
                if (kind < 7 || area < 2) begin
                    count = area;
                    push_run(count, need_start ? 1'b1 : 1'($urandom_range(0, 1)),
                             fill, 1'b0);
                    need_start = 1'b0;
                end else if (kind < 9) begin
                    count = $urandom_range(1, area - 1);
                    push_run(count, 1'b1, fill, 1'b0);
                    need_start = 1'b1;
                end else begin
                    count = $urandom_range(5, 60);
                    push_run(count, need_start ? 1'b1 : 1'($urandom_range(0, 1)),
                             FILL_RANDOM, 1'b1);
                    need_start = 1'b1;
                end
                random_items += count;
            end
        end

        // wind down: everything in, then a bounded wait for the last means
        sender_calm = 1'b0;
        sink_calm   = 1'b0;
        while (pixel_backlog.size() != 0 || s_valid) @(negedge aclk);
        waited = 0;
        while (owed_means.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        foreach (owed_means[i])
            report_mismatch("mean never delivered, row", '0, 12'(owed_means[i].row),
                            owed_means[i].row, owed_means[i].col);

        $display("%0d pixels in, %0d means checked, %0d register writes, %0d input stall cycles",
                 pixels_taken, means_checked, register_writes, input_stall_cycles);
        $display("frames from zero size to saturated widths, mid-frame shrinks, restarts, back pressure");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
